FILE: design/mrms_pkg.sv
// shared types for the multikey record merge sorter
`timescale 1ns / 1ps
package mrms_pkg;

   localparam int TAG_W = 6;
   localparam int FIELD_W = 16;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_SEG,
      ST_RD,
      ST_CMP,
      ST_OUT_RD,
      ST_OUT_SHOW
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_init;
      logic pass_init;
      logic pass_next;
      logic seg_init;
      logic seg_next;
      logic rd;
      logic step;
      logic out_init;
      logic rd_out;
      logic out_next;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pass_done;
      logic segs_done;
      logic seg_last;
      logic out_last;
   } dp_status_type;

endpackage

FILE: design/mrms_ctrl.sv
// sequencer for loading, merge passes and the output run
`timescale 1ns / 1ps
module mrms_ctrl
   import mrms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.sort_init = 1'b1;
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            if (status.pass_done) begin
               cmd.out_init = 1'b1;
               state_in = ST_OUT_RD;
            end else begin
               cmd.pass_init = 1'b1;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (status.segs_done) begin
               cmd.pass_next = 1'b1;
               state_in = ST_PASS;
            end else begin
               cmd.seg_init = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.step = 1'b1;
            if (status.seg_last) begin
               cmd.seg_next = 1'b1;
               state_in = ST_SEG;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_out = 1'b1;
            state_in = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.out_last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

FILE: design/mrms_datapath.sv
// record buffers, merge counters and key compare
`timescale 1ns / 1ps
module mrms_datapath
   import mrms_pkg::*;
#(
   parameter int MAX_RECORDS = 64,
   parameter int KEY_WIDTH   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic        [FIELD_W-1:0] req_points,
   input  logic signed [FIELD_W-1:0] req_score_diff,
   input  logic        [FIELD_W-1:0] req_tiebreak,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   output logic        [FIELD_W-1:0] rsp_out_points,
   output logic signed [FIELD_W-1:0] rsp_out_score_diff,
   output logic        [FIELD_W-1:0] rsp_out_tiebreak,
   output logic        [TAG_W-1:0]   rsp_arrival_tag,
   output logic                      rsp_dropped,
   output logic                      rsp_run_end
);

   localparam int IDX_W = $clog2(MAX_RECORDS);
   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int PW    = CNT_W + 2;
   localparam int REC_W = 3 * KEY_WIDTH + TAG_W;
   localparam int TIE_LO  = TAG_W;
   localparam int DIFF_LO = TAG_W + KEY_WIDTH;
   localparam int PTS_LO  = TAG_W + 2 * KEY_WIDTH;

   logic [REC_W-1:0] mem_a [MAX_RECORDS];
   logic [REC_W-1:0] mem_b [MAX_RECORDS];

   logic [CNT_W-1:0] count_ff;
   logic             ovf_ff;
   logic             par_ff;
   logic [PW-1:0]    w_ff, lo_ff, i_ff, j_ff, k_ff, mid_ff, hi_ff;
   logic [REC_W-1:0] rd_i_ff, rd_j_ff;

   logic [PW-1:0]    n_ext, mid_in, hi_in, lo_w, lo_2w;
   logic             take_j, j_before;
   logic [REC_W-1:0] wr_rec, new_rec;
   logic [IDX_W-1:0] ai, aj, ak;

   assign n_ext = PW'(count_ff);
   assign lo_w  = lo_ff + w_ff;
   assign lo_2w = lo_ff + (w_ff << 1);
   assign mid_in = (lo_w < n_ext) ? lo_w : n_ext;
   assign hi_in  = (lo_2w < n_ext) ? lo_2w : n_ext;
   assign ai = i_ff[IDX_W-1:0];
   assign aj = j_ff[IDX_W-1:0];
   assign ak = k_ff[IDX_W-1:0];

   always_comb begin
      if (rd_j_ff[PTS_LO +: KEY_WIDTH] != rd_i_ff[PTS_LO +: KEY_WIDTH]) begin
         j_before = rd_j_ff[PTS_LO +: KEY_WIDTH] > rd_i_ff[PTS_LO +: KEY_WIDTH];
      end else if (rd_j_ff[DIFF_LO +: KEY_WIDTH] != rd_i_ff[DIFF_LO +: KEY_WIDTH]) begin
         j_before = $signed(rd_j_ff[DIFF_LO +: KEY_WIDTH])
                  > $signed(rd_i_ff[DIFF_LO +: KEY_WIDTH]);
      end else begin
         j_before = rd_j_ff[TIE_LO +: KEY_WIDTH] < rd_i_ff[TIE_LO +: KEY_WIDTH];
      end
   end

   assign take_j  = (i_ff >= mid_ff) || ((j_ff < hi_ff) && j_before);
   assign wr_rec  = take_j ? rd_j_ff : rd_i_ff;
   assign new_rec = {KEY_WIDTH'(req_points), KEY_WIDTH'($unsigned(req_score_diff)),
                     KEY_WIDTH'(req_tiebreak), TAG_W'(count_ff)};

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CNT_W'(MAX_RECORDS))) begin
         mem_a[count_ff[IDX_W-1:0]] <= new_rec;
      end else if (cmd.step && par_ff) begin
         mem_a[ak] <= wr_rec;
      end
      if (cmd.step && !par_ff) begin
         mem_b[ak] <= wr_rec;
      end
      if (cmd.rd) begin
         rd_i_ff <= par_ff ? mem_b[ai] : mem_a[ai];
         rd_j_ff <= par_ff ? mem_b[aj] : mem_a[aj];
      end else if (cmd.rd_out) begin
         rd_i_ff <= par_ff ? mem_b[ak] : mem_a[ak];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.clear) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (count_ff < CNT_W'(MAX_RECORDS)) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         w_ff   <= PW'(1);
         par_ff <= 1'b0;
      end else if (cmd.pass_next) begin
         w_ff   <= w_ff << 1;
         par_ff <= ~par_ff;
      end
      if (cmd.pass_init) begin
         lo_ff <= '0;
      end else if (cmd.seg_next) begin
         lo_ff <= lo_2w;
      end
      if (cmd.seg_init) begin
         i_ff   <= lo_ff;
         j_ff   <= mid_in;
         k_ff   <= lo_ff;
         mid_ff <= mid_in;
         hi_ff  <= hi_in;
      end else if (cmd.step) begin
         k_ff <= k_ff + 1'b1;
         if (take_j) begin
            j_ff <= j_ff + 1'b1;
         end else begin
            i_ff <= i_ff + 1'b1;
         end
      end else if (cmd.out_init) begin
         k_ff <= '0;
      end else if (cmd.out_next) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   assign status.pass_done = w_ff >= n_ext;
   assign status.segs_done = lo_ff >= n_ext;
   assign status.seg_last  = (k_ff + 1'b1) == hi_ff;
   assign status.out_last  = (k_ff + 1'b1) == n_ext;

   assign rsp_out_points     = FIELD_W'(rd_i_ff[PTS_LO +: KEY_WIDTH]);
   assign rsp_out_score_diff = FIELD_W'($signed(rd_i_ff[DIFF_LO +: KEY_WIDTH]));
   assign rsp_out_tiebreak   = FIELD_W'(rd_i_ff[TIE_LO +: KEY_WIDTH]);
   assign rsp_arrival_tag    = rd_i_ff[TAG_W-1:0];
   assign rsp_dropped        = ovf_ff;
   assign rsp_run_end        = status.out_last;

endmodule

FILE: design/multikey_record_merge_sorter_core.sv
// top level of the multikey record merge sorter
`timescale 1ns / 1ps
// Records are taken one per cycle into a buffer of MAX_RECORDS entries; records past
// that are discarded and dropped is shown on every word of the set. The word marked
// last starts a stable bottom-up merge sort (points descending, score difference
// descending, tiebreak ascending) that ping-pongs between two buffers: each merged
// word is read from one buffer, compared and written to the other, over ceil(log2 n)
// passes. The run then leaves one word at a time, each read and then held until
// taken, the final word marked run_end. Input is stalled from last until the run is
// taken.
module multikey_record_merge_sorter_core
   import mrms_pkg::*;
#(
   parameter int MAX_RECORDS = 64,
   parameter int KEY_WIDTH   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic        [FIELD_W-1:0] req_points,
   input  logic signed [FIELD_W-1:0] req_score_diff,
   input  logic        [FIELD_W-1:0] req_tiebreak,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [FIELD_W-1:0] rsp_out_points,
   output logic signed [FIELD_W-1:0] rsp_out_score_diff,
   output logic        [FIELD_W-1:0] rsp_out_tiebreak,
   output logic        [TAG_W-1:0]   rsp_arrival_tag,
   output logic                      rsp_dropped,
   output logic                      rsp_run_end
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mrms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mrms_datapath #(
      .MAX_RECORDS (MAX_RECORDS),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_points         (req_points),
      .req_score_diff     (req_score_diff),
      .req_tiebreak       (req_tiebreak),
      .cmd                (cmd),
      .status             (status),
      .rsp_out_points     (rsp_out_points),
      .rsp_out_score_diff (rsp_out_score_diff),
      .rsp_out_tiebreak   (rsp_out_tiebreak),
      .rsp_arrival_tag    (rsp_arrival_tag),
      .rsp_dropped        (rsp_dropped),
      .rsp_run_end        (rsp_run_end)
   );

endmodule

FILE: design/mrms_checker.sv
// port checks for the merge sorter, bound to the top level
`timescale 1ns / 1ps
module mrms_checker
   import mrms_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic        [FIELD_W-1:0] rsp_out_points,
   input logic signed [FIELD_W-1:0] rsp_out_score_diff,
   input logic        [FIELD_W-1:0] rsp_out_tiebreak,
   input logic        [TAG_W-1:0]   rsp_arrival_tag,
   input logic                      rsp_dropped,
   input logic                      rsp_run_end
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_points)
         && $stable(rsp_out_score_diff) && $stable(rsp_out_tiebreak)
         && $stable(rsp_arrival_tag) && $stable(rsp_dropped) && $stable(rsp_run_end))
      else $error("stalled word changed");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input open while a run is out");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_run_end |=> !rsp_valid && !req_stall)
      else $error("run did not close after its final word");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind multikey_record_merge_sorter_core mrms_checker u_mrms_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_points     (rsp_out_points),
   .rsp_out_score_diff (rsp_out_score_diff),
   .rsp_out_tiebreak   (rsp_out_tiebreak),
   .rsp_arrival_tag    (rsp_arrival_tag),
   .rsp_dropped        (rsp_dropped),
   .rsp_run_end        (rsp_run_end)
);
